FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the button click classifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, off while reset is held
`define BCC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check on the block clock and reset names
`define BCC_ASSERT(label, prop, msg) \
    `BCC_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: sv/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// types and constants shared by the button click classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CLICK_W = 8;

    localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd400;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [CLICK_W-1:0] CLICK_MAX     = '1;

    // button levels
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    // event kinds
    localparam logic KIND_CLICK = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [CLICK_W-1:0] t_clicks;

    // one classified event from the step logic
    typedef struct packed {
        logic    valid;
        logic    event_kind;
        t_clicks clicks;
        t_count  held_ticks;
    } t_result;

endpackage

FILE: sv/bcc_if.sv
// ----------------------------------------------------------------------------
// bcc_if
// valid/ready channels for tick input and event output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bcc_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface bcc_out_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [7:0]  clicks;
    logic [15:0] held_ticks;

    modport source (output valid, output event_kind, output clicks, output held_ticks,
                    input ready);
    modport sink   (input valid, input event_kind, input clicks, input held_ticks,
                    output ready);
endinterface

FILE: sv/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// click sequence state and the single-tick classification logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_level,
    input  bcc_pkg::t_count   i_timeout,
    output bcc_pkg::t_result  o_res
);
    import bcc_pkg::*;

    logic    r_prev_level, n_prev_level;
    t_count  r_since_press, n_since_press;
    logic    r_armed, n_armed;
    t_clicks r_release_count, n_release_count;
    t_count  r_last_hold, n_last_hold;

    t_count  sp_inc;
    t_clicks rc_rel;
    t_count  lh_rel;
    logic    press_edge;
    logic    release_edge;
    logic    long_emit;
    logic    expire;
    logic    click_emit;
    logic    armed_mid;

    // one tick: advance, edges, then timeout
    always_comb begin
        sp_inc       = (r_since_press == COUNT_MAX) ? r_since_press : r_since_press + 1'b1;
        press_edge   = (r_prev_level == LEVEL_RELEASED) && (i_level == LEVEL_PRESSED);
        release_edge = (r_prev_level == LEVEL_PRESSED) && (i_level == LEVEL_RELEASED);

        n_since_press = press_edge ? '0 : sp_inc;
        armed_mid     = press_edge | r_armed;

        rc_rel = r_release_count;
        lh_rel = r_last_hold;
        if (release_edge) begin
            rc_rel = (r_release_count == CLICK_MAX) ? r_release_count
                                                    : r_release_count + 1'b1;
            lh_rel = sp_inc;
        end

        // release without armed timeout is a long press
        long_emit = release_edge & ~r_armed;

        // sequence closes once the counter passes the timeout or saturates
        expire = armed_mid &&
                 ((n_since_press > i_timeout) || (n_since_press == COUNT_MAX));
        click_emit = expire && !((i_level == LEVEL_PRESSED) && (rc_rel == '0));

        o_res.valid      = long_emit | click_emit;
        o_res.event_kind = long_emit ? KIND_LONG : KIND_CLICK;
        o_res.clicks     = long_emit ? rc_rel : (click_emit ? rc_rel : '0);
        o_res.held_ticks = lh_rel;

        n_prev_level    = i_level;
        n_armed         = expire ? 1'b0 : armed_mid;
        n_release_count = (long_emit | click_emit) ? '0 : rc_rel;
        n_last_hold     = (long_emit | click_emit) ? '0 : lh_rel;
    end

    // state update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level    <= LEVEL_RELEASED;
            r_since_press   <= '0;
            r_armed         <= 1'b0;
            r_release_count <= '0;
            r_last_hold     <= '0;
        end else if (i_step) begin
            r_prev_level    <= n_prev_level;
            r_since_press   <= n_since_press;
            r_armed         <= n_armed;
            r_release_count <= n_release_count;
            r_last_hold     <= n_last_hold;
        end
    end

endmodule

FILE: sv/button_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// multi-click and long-press classifier on a millisecond tick stream
// ----------------------------------------------------------------------------
// Each input transaction is one tick carrying the debounced button level
// (0 pressed). A tick is registered, classified combinationally against the
// click state, and any resulting event lands in an output register; ticks
// are taken every cycle while the output register is empty or being read,
// so the sustained rate is one tick per clock; a tick passes through the input
// register and then the output register. At most one event comes from a tick.
// timeout_ticks is written through i_cfg_we/i_cfg_wdata and resets to 400.
`timescale 1ns / 1ps

module button_click_classifier_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata,
    bcc_in_if.sink           i_in,
    bcc_out_if.source        o_out
);
    import bcc_pkg::*;

    t_count  r_timeout;
    logic    r_in_valid;
    logic    r_in_level;
    logic    r_out_valid;
    logic    r_out_kind;
    t_clicks r_out_clicks;
    t_count  r_out_held;
    logic    advance;
    logic    in_ready;
    t_result step_res;

    // a tick moves on when the output slot is free or draining
    assign advance  = r_in_valid & (~r_out_valid | o_out.ready);
    assign in_ready = ~r_in_valid | advance;
    assign i_in.ready = in_ready;

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_level <= i_in.button_level;
        end
    end

    // classification
    bcc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_level   (r_in_level),
        .i_timeout (r_timeout),
        .o_res     (step_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_res.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.valid) begin
            r_out_kind   <= step_res.event_kind;
            r_out_clicks <= step_res.clicks;
            r_out_held   <= step_res.held_ticks;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_out_kind;
    assign o_out.clicks     = r_out_clicks;
    assign o_out.held_ticks = r_out_held;

endmodule

FILE: sv/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// port-level checks on the button click classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [7:0]  i_out_clicks,
    input logic [15:0] i_out_held
);
    import bcc_pkg::*;

    // a stalled event keeps its payload
    `BCC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_out_kind, i_out_clicks, i_out_held}), "stalled event changed")

    // an empty output slot never blocks ticks
    `BCC_ASSERT(a_in_ready_free, !i_out_valid |-> i_in_ready, "tick refused with empty output")

    // a long press always follows at least one release
    `BCC_ASSERT(a_long_has_click, i_out_valid && i_out_kind == KIND_LONG |-> i_out_clicks != 8'd0, "long press without click")

    // hold time is only recorded together with a release
    `BCC_ASSERT(a_hold_needs_click, i_out_valid && i_out_clicks == 8'd0 |-> i_out_held == 16'd0, "hold time without click")

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_kind   (o_out.event_kind),
    .i_out_clicks (o_out.clicks),
    .i_out_held   (o_out.held_ticks)
);
